### rtl/cira_pkg.sv
// ----------------------------------------------------------------------------
// cira_pkg: shared types and constants for the IRQ range allocator
// Status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package cira_pkg;

  // default bitmap size, in interrupt numbers
  localparam int MapBitsDef = 256;

  // field widths fixed by the interface
  localparam int ReqW    = 9;
  localparam int FromW   = 8;
  localparam int CountW  = 9;
  localparam int LimitW  = 9;
  localparam int FirstW  = 8;
  localparam int StatusW = 2;

  localparam logic [LimitW-1:0] LimitRst = 9'd256;

  typedef enum logic [StatusW-1:0] {
    CIRA_OK      = 2'd0,
    CIRA_INVALID = 2'd1,
    CIRA_EXISTS  = 2'd2,
    CIRA_RANGE   = 2'd3
  } cira_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,  // post-reset sweep of the bitmap
    S_IDLE,   // waiting for a request
    S_RD,     // issue bitmap read
    S_CHK,    // examine read bit
    S_WR,     // mark granted run
    S_DONE    // result waiting for the output register
  } cira_state_t;

endpackage

### rtl/contiguous_irq_range_allocator_core.sv
// ----------------------------------------------------------------------------
// contiguous_irq_range_allocator_core: bitmap allocator for IRQ number runs
// Finds, marks and returns runs of consecutive free interrupt numbers.
// ----------------------------------------------------------------------------
// The block keeps one allocation bit per interrupt number in a RAM of
// MAP_BITS x 1. Each request carries a count, a search start and either a
// fixed first number or -1 (any place). The answer is one transfer on the
// out channel: status (0 ok, 1 invalid, 2 fixed run taken or off the map, 3 out of
// range) and the first number of the run, which reads 0 unless status is ok.
// Sequence: after reset the bitmap is swept clear, one entry per cycle;
// in_stall is high during the sweep (cfg writes still go through). A request
// is then handled by one sequencer that walks the bitmap one bit at a time
// (RAM read, then check) and then marks the granted run; rejected requests
// that fail the up-front checks go straight to the result state. The block
// takes one request at a time: in_stall stays high from accept until the
// result has been moved into the output register, which can still hold the
// previous result while the next request is scanned. The limit register is
// written through the cfg channel, which is always ready; write it only
// while idle.
// ----------------------------------------------------------------------------
module contiguous_irq_range_allocator_core
  import cira_pkg::*;
#(
  parameter int MAP_BITS = MapBitsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ReqW-1:0]    in_requested_irq,
  input  logic [FromW-1:0]          in_search_from,
  input  logic [CountW-1:0]         in_count,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [StatusW-1:0]        out_status,
  output logic [FirstW-1:0]         out_first_irq,
  // limit register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [LimitW-1:0]         cfg_irq_limit
);

  // address width, counter width (holds MAP_BITS and any count), sum width
  localparam int AW = $clog2(MAP_BITS);
  localparam int CW = ((AW + 1) > CountW) ? (AW + 1) : CountW;
  localparam int SW = CW + 1;

  localparam logic [AW:0]   MapEndA = (AW + 1)'(MAP_BITS);
  localparam logic [SW-1:0] MapEndS = SW'(MAP_BITS);

  cira_state_t             state_r, state_nxt;
  logic [LimitW-1:0]       limit_r;
  logic [AW:0]             addr_r, addr_nxt;     // scan / write pointer
  logic [CW-1:0]           run_r, run_nxt;       // free-run length, then bits left
  logic [CountW-1:0]       cnt_r, cnt_nxt;
  logic                    fixed_r, fixed_nxt;
  logic [AW-1:0]           start_r, start_nxt;
  cira_status_t            res_st_r, res_st_nxt; // result held until out reg frees
  logic                    out_valid_r, out_valid_nxt;
  cira_status_t            out_st_r, out_st_nxt;
  logic [FirstW-1:0]       out_first_r, out_first_nxt;

  // bitmap port
  logic                    ram_we;
  logic                    ram_wdata;
  logic                    ram_rdata;

  // request decode
  logic                    in_fire;
  logic                    req_fixed;
  logic [FromW-1:0]        req_val;
  logic [SW-1:0]           req_end;

  // scan arithmetic
  logic [AW:0]             addr_inc;
  logic [CW-1:0]           run_inc;
  logic [SW-1:0]           run_start;
  logic                    out_free;

  assign in_fire   = in_valid && !in_stall;
  assign req_fixed = !in_requested_irq[ReqW-1];
  assign req_val   = in_requested_irq[FromW-1:0];
  assign req_end   = SW'(req_val) + SW'(in_count);

  assign addr_inc  = addr_r + 1'b1;
  assign run_inc   = run_r + 1'b1;
  assign run_start = SW'(addr_inc) - SW'(cnt_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_status    = out_st_r;
  assign out_first_irq = out_first_r;

  cira_ram #(
    .Width (1),
    .Depth (MAP_BITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---- state and control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LimitRst;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_irq_limit;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    run_r       <= run_nxt;
    cnt_r       <= cnt_nxt;
    fixed_r     <= fixed_nxt;
    start_r     <= start_nxt;
    res_st_r    <= res_st_nxt;
    out_st_r    <= out_st_nxt;
    out_first_r <= out_first_nxt;
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    fixed_nxt     = fixed_r;
    start_nxt     = start_r;
    res_st_nxt    = res_st_r;
    out_st_nxt    = out_st_r;
    out_first_nxt = out_first_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_wdata     = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // zero one bitmap entry per cycle
        ram_we   = 1'b1;
        addr_nxt = addr_inc;
        if (addr_inc == MapEndA) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt   = in_count;
          fixed_nxt = req_fixed;
          run_nxt   = '0;
          if (in_count == '0) begin
            res_st_nxt = CIRA_INVALID;
            state_nxt  = S_DONE;
          end else if (req_fixed) begin
            if (in_search_from > req_val) begin
              res_st_nxt = CIRA_INVALID;
              state_nxt  = S_DONE;
            end else if (req_end > MapEndS) begin
              // run would run off the end of the map
              res_st_nxt = CIRA_EXISTS;
              state_nxt  = S_DONE;
            end else begin
              addr_nxt  = (AW + 1)'(req_val);
              state_nxt = S_RD;
            end
          end else begin
            if (SW'(in_search_from) >= MapEndS) begin
              res_st_nxt = CIRA_RANGE;
              state_nxt  = S_DONE;
            end else begin
              addr_nxt  = (AW + 1)'(in_search_from);
              state_nxt = S_RD;
            end
          end
        end
      end

      S_RD: begin
        state_nxt = S_CHK;
      end

      S_CHK: begin
        if (ram_rdata) begin
          run_nxt = '0;
          if (fixed_r) begin
            res_st_nxt = CIRA_EXISTS;
            state_nxt  = S_DONE;
          end else if (addr_inc == MapEndA) begin
            res_st_nxt = CIRA_RANGE;
            state_nxt  = S_DONE;
          end else begin
            addr_nxt  = addr_inc;
            state_nxt = S_RD;
          end
        end else if (run_inc == CW'(cnt_r)) begin
          // run found: addr_inc is one past its last bit
          start_nxt = run_start[AW-1:0];
          if (SW'(addr_inc) > SW'(limit_r)) begin
            res_st_nxt = CIRA_RANGE;
            state_nxt  = S_DONE;
          end else begin
            addr_nxt  = (AW + 1)'(run_start);
            run_nxt   = CW'(cnt_r);
            state_nxt = S_WR;
          end
        end else begin
          run_nxt = run_inc;
          if (addr_inc == MapEndA) begin
            res_st_nxt = CIRA_RANGE;
            state_nxt  = S_DONE;
          end else begin
            addr_nxt  = addr_inc;
            state_nxt = S_RD;
          end
        end
      end

      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        addr_nxt  = addr_inc;
        run_nxt   = run_r - 1'b1;
        if (run_r == CW'(1)) begin
          res_st_nxt = CIRA_OK;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_first_nxt = (res_st_r == CIRA_OK) ? FirstW'(start_r) : '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/cira_ram.sv
// ----------------------------------------------------------------------------
// cira_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cira_ram #(
  parameter int Width = 1,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/cira_chk.sv
// ----------------------------------------------------------------------------
// cira_chk: port-level checks for the IRQ range allocator
// Attached to the top level by the bind at the end of this file.
// ----------------------------------------------------------------------------
module cira_chk
  import cira_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [StatusW-1:0]     out_status,
  input logic [FirstW-1:0]      out_first_irq
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_first_irq))
    else $error("stalled result changed");

  // failed requests report first number zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != CIRA_OK) |-> out_first_irq == '0)
    else $error("nonzero first_irq on failure");

  // one request at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind contiguous_irq_range_allocator_core cira_chk u_cira_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_first_irq (out_first_irq)
);

### tb/sv/cira_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cira_checker: result predictor and scoreboard for the IRQ range allocator
// Mirrors the allocation bitmap and limit register from observed transfers,
// predicts each request's answer and compares it with the result channel.
// ----------------------------------------------------------------------------
module cira_checker
  import cira_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic signed [ReqW-1:0] in_requested_irq,
  input  logic [FromW-1:0]       in_search_from,
  input  logic [CountW-1:0]      in_count,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [StatusW-1:0]     out_status,
  input  logic [FirstW-1:0]      out_first_irq,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [LimitW-1:0]      cfg_irq_limit,
  output int                     mismatch_count,
  output int                     results_owed
);

  localparam int MapBits = MapBitsDef;

  typedef struct packed {
    cira_status_t        status;
    logic [FirstW-1:0]   first_irq;
  } grant_t;

  logic [MapBits-1:0] taken_map;
  logic [LimitW-1:0]  irq_limit_q;
  grant_t             grants_due[$];
  int                 errors = 0;

  // run of len numbers starting at first lies inside the map and is all free
  function automatic bit span_free(int first, int len);
    if (first > MapBits || len > MapBits - first) return 1'b0;
    for (int i = 0; i < len; i++)
      if (taken_map[first + i]) return 1'b0;
    return 1'b1;
  endfunction

  // answer one request and mark the run on success
  function automatic grant_t allocate_run(logic [ReqW-1:0] req, logic [FromW-1:0] from,
                                          logic [CountW-1:0] cnt);
    grant_t g;
    int     start;
    bit     found;
    g.status    = CIRA_OK;
    g.first_irq = '0;
    start       = 0;
    found       = 1'b0;
    if (cnt == 0) begin
      g.status = CIRA_INVALID;
    end else if (!req[ReqW-1]) begin
      if (int'(from) > int'(req)) begin
        g.status = CIRA_INVALID;
      end else if (!span_free(int'(req), int'(cnt))) begin
        g.status = CIRA_EXISTS;
      end else begin
        start = int'(req);
        found = 1'b1;
      end
    end else begin
      for (int s = int'(from); s < MapBits && !found; s++) begin
        if (span_free(s, int'(cnt))) begin
          start = s;
          found = 1'b1;
        end
      end
      if (!found) g.status = CIRA_RANGE;
    end
    if (found && start + int'(cnt) > int'(irq_limit_q)) begin
      found    = 1'b0;
      g.status = CIRA_RANGE;
    end
    if (found) begin
      for (int i = 0; i < int'(cnt); i++) taken_map[start + i] = 1'b1;
      g.first_irq = start[FirstW-1:0];
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      taken_map   = '0;
      irq_limit_q = LimitRst;
      grants_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) irq_limit_q = cfg_irq_limit;
      if (in_valid && !in_stall)
        grants_due.push_back(allocate_run(in_requested_irq, in_search_from, in_count));
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result status=%0d first_irq=%0d", $realtime,
                     out_status, out_first_irq);
        end else begin
          want = grants_due.pop_front();
          if (out_status !== want.status || out_first_irq !== want.first_irq) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch status exp=%0d act=%0d first_irq exp=%0d act=%0d",
                       $realtime, want.status, out_status, want.first_irq, out_first_irq);
          end
        end
      end
    end
    mismatch_count <= errors;
    results_owed   <= grants_due.size();
  end

endmodule

### tb/sv/contiguous_irq_range_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_irq_range_allocator_core_tb: top level test of the IRQ allocator
// Drives directed and random allocation requests in bursts under several
// limit settings, stalls the result side on its own pattern, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module contiguous_irq_range_allocator_core_tb
  import cira_pkg::*;
();

  // cycles without any transfer before the run is declared hung; a full
  // any-place scan of a large count over a fragmented map is the slow case
  localparam int IdleLimit   = 300000;
  // settle time after the last result
  localparam int DrainCycles = 20;
  // length of the forced receiver hold-off
  localparam int HoldCycles  = 400;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_stall;
  logic signed [ReqW-1:0] in_requested_irq = '0;
  logic [FromW-1:0]       in_search_from   = '0;
  logic [CountW-1:0]      in_count         = '0;
  logic                   out_valid;
  logic                   out_stall        = 1'b0;
  logic [StatusW-1:0]     out_status;
  logic [FirstW-1:0]      out_first_irq;
  logic                   cfg_valid        = 1'b0;
  logic                   cfg_ready;
  logic [LimitW-1:0]      cfg_irq_limit    = LimitRst;

  int chk_errors;
  int chk_owed;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  contiguous_irq_range_allocator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_requested_irq (in_requested_irq),
    .in_search_from   (in_search_from),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_first_irq    (out_first_irq),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_irq_limit    (cfg_irq_limit)
  );

  cira_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_requested_irq (in_requested_irq),
    .in_search_from   (in_search_from),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_first_irq    (out_first_irq),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_irq_limit    (cfg_irq_limit),
    .mismatch_count   (chk_errors),
    .results_owed     (chk_owed)
  );

  // watchdog: any transfer on any channel restarts the count; the post-reset
  // bitmap sweep and the forced hold-off both fit well inside the limit
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: segments of free flow, random stalls and mostly-stalled
  // stretches; on request one long hold-off so the block backs up into
  // the request channel
  initial begin : receiver
    int mode;
    int span;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(1, 60);
        repeat (span) begin
          case (mode)
            0: begin
              out_stall <= 1'b0;
            end
            1: begin
              out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_stall <= ($urandom_range(0, 3) != 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // All tasks below start and end on a rising edge. Valid is left high when
  // one transfer ends so a burst runs back to back without a dropout.
  task automatic offer_request(logic [ReqW-1:0] req, logic [FromW-1:0] from,
                               logic [CountW-1:0] cnt);
    in_valid         <= 1'b1;
    in_requested_irq <= req;
    in_search_from   <= from;
    in_count         <= cnt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // pause the sender until every predicted result has been taken; the
  // checker's count is registered, hence the edge before the first look
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk_owed != 0);
  endtask

  // limit write, issued while the block is idle, but once during the reset sweep
  task automatic write_limit(logic [LimitW-1:0] v);
    cfg_valid     <= 1'b1;
    cfg_irq_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly short runs so the map does not fill in the first few dozen grants
  function automatic logic [CountW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 9'd1;
    if (r < 93) return 9'($urandom_range(2, 3));
    if (r < 99) return 9'($urandom_range(4, 8));
    return 9'($urandom_range(9, 256));
  endfunction

  task automatic offer_random();
    logic [ReqW-1:0]   req;
    logic [FromW-1:0]  from;
    logic [CountW-1:0] cnt;
    int                kind;
    kind = $urandom_range(0, 99);
    cnt  = pick_count();
    if (kind < 55) begin
      // any place; any negative value means any, -1 is the usual form
      req  = {1'b1, 8'($urandom)};
      if ($urandom_range(0, 3) == 0) req = 9'h1FF;
      from = $urandom_range(0, 1) ? 8'($urandom_range(0, 63)) : 8'($urandom);
    end else if (kind < 85) begin
      // well-formed fixed request
      req  = 9'($urandom_range(0, 255));
      from = 8'($urandom_range(0, int'(req)));
    end else if (kind < 92) begin
      // fixed number below the search start
      req  = 9'($urandom_range(0, 254));
      from = 8'($urandom_range(int'(req) + 1, 255));
    end else begin
      // noise: zero count or oversized runs with arbitrary fields
      req  = 9'($urandom);
      from = 8'($urandom);
      cnt  = (kind < 96) ? 9'd0 : 9'($urandom_range(200, 256));
    end
    offer_request(req, from, cnt);
  endtask

  // one limit setting, then random bursts with gaps; now and then the
  // sender waits for the block to empty instead of a plain gap
  task automatic run_phase(int n_items, logic [LimitW-1:0] limit, bit squeeze);
    int sent;
    int burst;
    sent = 0;
    write_limit(limit);
    if (squeeze) hold_request = 1'b1;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 5) == 0) burst = $urandom_range(20, 40);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        offer_random();
        sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_all_results();
      else idle_gap($urandom_range(1, 20));
    end
    wait_all_results();
  endtask

  initial begin : stimulus
    // single synchronous reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // limit write lands during the clearing sweep, which the block allows
    write_limit(LimitRst);

    // directed: zero count, fixed below start, fixed taken, run off the end
    // of the map, any-place with no room, most negative request value
    offer_request(9'h1FF, 8'd0,   9'd0);     // zero count, any place
    offer_request(9'd5,   8'd0,   9'd0);     // zero count, fixed
    offer_request(9'd10,  8'd20,  9'd1);     // fixed below search start
    offer_request(9'd0,   8'd0,   9'd1);     // first number
    offer_request(9'd0,   8'd0,   9'd1);     // same place again: taken
    offer_request(9'h1FF, 8'd0,   9'd1);     // lowest free
    offer_request(9'h1FF, 8'd255, 9'd1);     // last number
    offer_request(9'h1FF, 8'd255, 9'd2);     // no run fits in the map
    offer_request(9'd255, 8'd255, 9'd2);     // fixed run past map end
    offer_request(9'd254, 8'd0,   9'd1);
    offer_request(9'h1FF, 8'd0,   9'd256);   // whole map, partly used
    offer_request(9'd0,   8'd0,   9'd256);   // fixed whole map: taken
    offer_request(9'h100, 8'd3,   9'd4);     // most negative means any
    offer_request(9'd100, 8'd100, 9'd16);
    offer_request(9'd108, 8'd50,  9'd1);     // inside granted run
    offer_request(9'h1FF, 8'd100, 9'd3);     // skips the granted run
    wait_all_results();

    // run that fits the map but ends past the limit
    write_limit(9'd20);
    offer_request(9'h1FF, 8'd0,   9'd4);
    offer_request(9'h1FF, 8'd10,  9'd16);    // ends past 20
    offer_request(9'd19,  8'd19,  9'd1);     // last number under the limit
    offer_request(9'd19,  8'd0,   9'd2);     // fixed run past the limit; 19 is now taken
    wait_all_results();

    // smallest limit: only number 0 could ever fit, and it is taken
    write_limit(9'd1);
    offer_request(9'h1FF, 8'd0,   9'd1);
    offer_request(9'd0,   8'd0,   9'd1);
    wait_all_results();

    // random part; the first phase carries the long receiver hold-off
    run_phase(90, LimitRst, 1'b1);
    run_phase(90, 9'd128, 1'b0);
    run_phase(90, 9'($urandom_range(2, 254)), 1'b0);
    run_phase(90, 9'd1, 1'b0);
    run_phase(90, 9'd255, 1'b0);
    run_phase(90, LimitRst, 1'b0);

    repeat (DrainCycles) @(posedge clk);
    if (chk_errors == 0 && chk_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cira_pkg.sv
rtl/cira_ram.sv
rtl/contiguous_irq_range_allocator_core.sv
rtl/cira_chk.sv
tb/sv/cira_checker.sv
tb/sv/contiguous_irq_range_allocator_core_tb.sv
